### hdl/ccr_pkg.sv
// ----------------------------------------------------------------------------
// Command router package
// Widths, opcodes, sequencer states and the duplicate-update mask lookup
// shared by the command router and its word buffer.
// ----------------------------------------------------------------------------
package ccr_pkg;

    localparam int BLOCKS = 16;
    localparam int POS_W  = $clog2(BLOCKS);
    localparam int WORD_W = 32;
    localparam int DEST_W = BLOCKS;
    localparam int CMD_W  = 4;
    localparam int PAR_W  = 3;
    localparam int CNT_W  = 7;
    localparam int LANE_W = 4;
    localparam int GRP_LO = 3;
    localparam int GRP_W  = CNT_W - GRP_LO;

    localparam logic [CMD_W-1:0] OP_SEARCH    = 4'h5;
    localparam logic [CMD_W-1:0] OP_SET_TABLE = 4'h6;
    localparam logic [CMD_W-1:0] OP_RESET     = 4'h7;
    localparam logic [CMD_W-1:0] OP_DUP       = 4'h8;

    localparam logic [PAR_W-1:0] PAR_X1  = 3'd1;
    localparam logic [PAR_W-1:0] PAR_X2  = 3'd2;
    localparam logic [PAR_W-1:0] PAR_X4  = 3'd3;
    localparam logic [PAR_W-1:0] PAR_X8  = 3'd4;
    localparam logic [PAR_W-1:0] PAR_X16 = 3'd5;

    localparam logic [POS_W-1:0]  LAST_POS   = POS_W'(BLOCKS - 1);
    localparam logic [DEST_W-1:0] ALL_BLOCKS = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TBL_RD,
        ST_TBL_WR,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } t_state;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_BUF,
        MODE_SEARCH
    } t_mode;

    function automatic logic [DEST_W-1:0] dup_mask(input logic [PAR_W-1:0] par,
                                                   input logic [GRP_W-1:0] grp);
        logic [DEST_W-1:0] m;
        m = '0;
        unique case (par)
            PAR_X1: begin
                m = 16'h0001 << grp;
            end
            PAR_X2: begin
                if (grp < 4'd8) m = 16'h0101 << grp[2:0];
            end
            PAR_X4: begin
                if (grp < 4'd4) m = 16'h1111 << grp[1:0];
            end
            PAR_X8: begin
                if (grp == 4'd0) m = 16'h5555;
                else if (grp == 4'd1) m = 16'hAAAA;
            end
            PAR_X16: begin
                if (grp == 4'd0) m = 16'hFFFF;
            end
            default: begin
                m = '0;
            end
        endcase
        return m;
    endfunction

endpackage

### hdl/ccr_word_buf.sv
// ----------------------------------------------------------------------------
// Command router word buffer
// Sixteen-word packet store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ccr_word_buf (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [ccr_pkg::POS_W-1:0]  i_wr_addr,
    input  logic [ccr_pkg::WORD_W-1:0] i_wr_data,
    input  logic [ccr_pkg::POS_W-1:0]  i_rd_addr,
    output logic [ccr_pkg::WORD_W-1:0] o_rd_data
);
    import ccr_pkg::*;

    logic [WORD_W-1:0] r_mem [BLOCKS];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/cam_command_router.sv
// ----------------------------------------------------------------------------
// Command router
// Buffers sixteen-word command packets and re-emits them, routed to a mask of
// destination blocks, once the last word of a packet has arrived.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  input     in         i_valid / o_stall   command, parallelism, header_top,
//                                           word, word_pos, stream_end
//  output    out        o_valid / i_stall   dest, header fields, word, pos,
//                                           packet_last, stream_last
//
// A word that is not the last of its packet is only written to the buffer.
// The last word starts a sequence that emits sixteen words, each going through
// read, load and transfer states on the single buffer read port. Set table
// first sweeps the buffer through table read and write states to copy the lane
// indices out. An unknown opcode returns to idle at once. The input is stalled
// while a packet is being sent. Reset is synchronous and clears the lane table.
// ----------------------------------------------------------------------------
module cam_command_router (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [ccr_pkg::CMD_W-1:0]  i_command,
    input  logic [ccr_pkg::PAR_W-1:0]  i_parallelism,
    input  logic                      i_header_top,
    input  logic [ccr_pkg::WORD_W-1:0] i_word,
    input  logic [ccr_pkg::POS_W-1:0]  i_word_pos,
    input  logic                      i_stream_end,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [ccr_pkg::DEST_W-1:0] o_dest,
    output logic                      o_out_header_top,
    output logic [ccr_pkg::CMD_W-1:0]  o_out_command,
    output logic [ccr_pkg::PAR_W-1:0]  o_out_parallelism,
    output logic [ccr_pkg::WORD_W-1:0] o_out_word,
    output logic [ccr_pkg::POS_W-1:0]  o_out_pos,
    output logic                      o_packet_last,
    output logic                      o_stream_last
);
    import ccr_pkg::*;

    t_state              r_state, n_state;
    t_mode               r_mode, n_mode;
    logic [POS_W-1:0]    r_cnt, n_cnt;
    logic [LANE_W-1:0]   r_lane [BLOCKS];
    logic                lane_we;
    logic [CNT_W-1:0]    r_dup_cnt, n_dup_cnt;
    logic [DEST_W-1:0]   r_held_dest, n_held_dest;
    logic                r_hdr_top, n_hdr_top;
    logic [CMD_W-1:0]    r_hdr_cmd, n_hdr_cmd;
    logic [PAR_W-1:0]    r_hdr_par, n_hdr_par;
    logic                r_stream_last, n_stream_last;
    logic                r_out_valid, n_out_valid;
    logic [WORD_W-1:0]   r_out_word, n_out_word;
    logic                in_xfer;
    logic                out_xfer;
    logic [POS_W-1:0]    rd_addr;
    logic [WORD_W-1:0]   rd_data;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;

    ccr_word_buf u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (in_xfer),
        .i_wr_addr (i_word_pos),
        .i_wr_data (i_word),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_mode        <= MODE_ZERO;
            r_cnt         <= '0;
            r_dup_cnt     <= '0;
            r_held_dest   <= '0;
            r_hdr_top     <= 1'b0;
            r_hdr_cmd     <= '0;
            r_hdr_par     <= '0;
            r_stream_last <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_mode        <= n_mode;
            r_cnt         <= n_cnt;
            r_dup_cnt     <= n_dup_cnt;
            r_held_dest   <= n_held_dest;
            r_hdr_top     <= n_hdr_top;
            r_hdr_cmd     <= n_hdr_cmd;
            r_hdr_par     <= n_hdr_par;
            r_stream_last <= n_stream_last;
            r_out_valid   <= n_out_valid;
        end
        r_out_word <= n_out_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BLOCKS; i++) begin
                r_lane[i] <= '0;
            end
        end else if (lane_we) begin
            r_lane[r_cnt] <= rd_data[LANE_W-1:0];
        end
    end

    always_comb begin
        n_state       = r_state;
        n_mode        = r_mode;
        n_cnt         = r_cnt;
        n_dup_cnt     = r_dup_cnt;
        n_held_dest   = r_held_dest;
        n_hdr_top     = r_hdr_top;
        n_hdr_cmd     = r_hdr_cmd;
        n_hdr_par     = r_hdr_par;
        n_stream_last = r_stream_last;
        n_out_valid   = r_out_valid;
        n_out_word    = r_out_word;
        o_stall       = 1'b1;
        lane_we       = 1'b0;
        rd_addr       = r_cnt;

        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid && i_word_pos == LAST_POS) begin
                    n_cnt = '0;
                    if (i_stream_end) begin
                        n_hdr_top     = 1'b0;
                        n_hdr_cmd     = '0;
                        n_hdr_par     = '0;
                        n_dup_cnt     = '0;
                        n_mode        = MODE_ZERO;
                        n_stream_last = 1'b1;
                        n_state       = ST_EMIT_RD;
                    end else begin
                        n_stream_last = 1'b0;
                        if (i_command != OP_DUP) begin
                            n_dup_cnt = '0;
                        end
                        unique case (i_command) inside
                            OP_SET_TABLE: begin
                                n_held_dest = ALL_BLOCKS;
                                n_hdr_cmd   = OP_RESET;
                                n_mode      = MODE_ZERO;
                                n_state     = ST_TBL_RD;
                            end
                            OP_DUP: begin
                                n_held_dest = dup_mask(i_parallelism,
                                                       r_dup_cnt[CNT_W-1:GRP_LO]);
                                n_hdr_top   = i_header_top;
                                n_hdr_cmd   = i_command;
                                n_hdr_par   = i_parallelism;
                                n_dup_cnt   = r_dup_cnt + CNT_W'(1);
                                n_mode      = MODE_BUF;
                                n_state     = ST_EMIT_RD;
                            end
                            OP_SEARCH, OP_RESET: begin
                                n_held_dest = ALL_BLOCKS;
                                n_hdr_top   = i_header_top;
                                n_hdr_cmd   = i_command;
                                n_hdr_par   = i_parallelism;
                                n_mode      = (i_command == OP_SEARCH) ? MODE_SEARCH
                                                                       : MODE_BUF;
                                n_state     = ST_EMIT_RD;
                            end
                            default: begin
                                n_state = ST_IDLE;
                            end
                        endcase
                    end
                end
            end
            ST_TBL_RD: begin
                n_state = ST_TBL_WR;
            end
            ST_TBL_WR: begin
                lane_we = 1'b1;
                if (r_cnt == LAST_POS) begin
                    n_cnt   = '0;
                    n_state = ST_EMIT_RD;
                end else begin
                    n_cnt   = r_cnt + POS_W'(1);
                    n_state = ST_TBL_RD;
                end
            end
            ST_EMIT_RD: begin
                if (r_mode == MODE_SEARCH) begin
                    rd_addr = r_lane[r_cnt];
                end
                n_state = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                n_out_word  = (r_mode == MODE_ZERO) ? '0 : rd_data;
                n_out_valid = 1'b1;
                n_state     = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (out_xfer) begin
                    n_out_valid = 1'b0;
                    if (r_cnt == LAST_POS) begin
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt   = r_cnt + POS_W'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid           = r_out_valid;
    assign o_dest            = r_held_dest;
    assign o_out_header_top  = r_hdr_top;
    assign o_out_command     = r_hdr_cmd;
    assign o_out_parallelism = r_hdr_par;
    assign o_out_word        = r_out_word;
    assign o_out_pos         = r_cnt;
    assign o_packet_last     = (r_cnt == LAST_POS);
    assign o_stream_last     = r_stream_last;

    a_valid_only_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == ST_EMIT_WAIT)
        else $error("output valid outside the transfer wait state");

    a_no_input_while_sending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !r_out_valid)
        else $error("input taken while a result is pending");

    a_last_word_ends_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && o_packet_last |=> r_state == ST_IDLE && r_cnt == '0)
        else $error("sequencer did not return to idle after the last word");

    a_table_write_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_TBL_WR |-> $past(r_state) == ST_TBL_RD)
        else $error("lane table written without a preceding buffer read");

    a_header_stable_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT_WAIT && !out_xfer |=> $stable(r_held_dest) && $stable(r_hdr_cmd))
        else $error("packet header changed while a word was pending");

endmodule

### bench/cam_command_router_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command router testbench
// Drives word transfers into the router and predicts every routed word from
// its own copy of the packet buffer, lane table, duplicate count and held
// header. Directed packets cover each opcode, the terminator and every
// duplicate row, then random traffic and a dup sweep span four idling phases.
// ----------------------------------------------------------------------------
module cam_command_router_tb;

    import ccr_pkg::*;

    localparam logic [CMD_W-1:0] OP_IGNORED = 4'hF;
    localparam logic [PAR_W-1:0] PAR_NONE   = 3'd0;
    localparam int               IDLE_LIMIT = 4000;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PAR_W-1:0]  par;
        logic              top;
        logic [WORD_W-1:0] word;
        logic [POS_W-1:0]  pos;
        logic              s_end;
    } t_cmd_word;

    typedef struct packed {
        logic [DEST_W-1:0] dest;
        logic              top;
        logic [CMD_W-1:0]  command;
        logic [PAR_W-1:0]  par;
        logic [WORD_W-1:0] word;
        logic [POS_W-1:0]  pos;
        logic              pkt_last;
        logic              strm_last;
    } t_routed_word;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [CMD_W-1:0]  i_command;
    logic [PAR_W-1:0]  i_parallelism;
    logic              i_header_top;
    logic [WORD_W-1:0] i_word;
    logic [POS_W-1:0]  i_word_pos;
    logic              i_stream_end;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [DEST_W-1:0] o_dest;
    logic              o_out_header_top;
    logic [CMD_W-1:0]  o_out_command;
    logic [PAR_W-1:0]  o_out_parallelism;
    logic [WORD_W-1:0] o_out_word;
    logic [POS_W-1:0]  o_out_pos;
    logic              o_packet_last;
    logic              o_stream_last;

    logic [WORD_W-1:0] word_mem [BLOCKS];
    logic [WORD_W-1:0] emit_words [BLOCKS];
    logic [LANE_W-1:0] lane_map [BLOCKS];
    logic [CNT_W-1:0]  dup_run;
    logic [DEST_W-1:0] route_dest;
    logic [7:0]        route_hdr;

    t_routed_word routed_words [$];

    int send_gap_pct = 0;
    int stall_pct    = 0;
    int errors       = 0;
    int in_count     = 0;
    int out_count    = 0;
    int idle_cycles  = 0;

    cam_command_router u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_command         (i_command),
        .i_parallelism     (i_parallelism),
        .i_header_top      (i_header_top),
        .i_word            (i_word),
        .i_word_pos        (i_word_pos),
        .i_stream_end      (i_stream_end),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_dest            (o_dest),
        .o_out_header_top  (o_out_header_top),
        .o_out_command     (o_out_command),
        .o_out_parallelism (o_out_parallelism),
        .o_out_word        (o_out_word),
        .o_out_pos         (o_out_pos),
        .o_packet_last     (o_packet_last),
        .o_stream_last     (o_stream_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_cmd_word pack_word(input logic [CMD_W-1:0] command,
                                            input logic [PAR_W-1:0] par,
                                            input logic top,
                                            input logic [WORD_W-1:0] word,
                                            input logic [POS_W-1:0] pos,
                                            input logic s_end);
        t_cmd_word w;
        w.command = command;
        w.par     = par;
        w.top     = top;
        w.word    = word;
        w.pos     = pos;
        w.s_end   = s_end;
        return w;
    endfunction

    // Each valid parallelism code spreads the mask at a stride of 16, 8, 4, 2 or 1
    // blocks; the count group picks the offset, and groups past the stride are empty.
    function automatic logic [DEST_W-1:0] dup_dest(input logic [PAR_W-1:0] par,
                                                   input logic [CNT_W-1:0] count);
        logic [DEST_W-1:0] m;
        int stride;
        int grp;
        int b;
        m = '0;
        grp = int'(count >> GRP_LO);
        if (par >= PAR_X1 && par <= PAR_X16) begin
            stride = DEST_W >> (par - PAR_X1);
            for (b = 0; b < DEST_W; b++) begin
                if (grp < stride && (b % stride) == grp) m[b] = 1'b1;
            end
        end
        return m;
    endfunction

    task automatic queue_packet(input logic terminator);
        t_routed_word r;
        int k;
        for (k = 0; k < BLOCKS; k++) begin
            r.dest      = route_dest;
            r.top       = route_hdr[7];
            r.command   = route_hdr[6:3];
            r.par       = route_hdr[2:0];
            r.word      = emit_words[k];
            r.pos       = POS_W'(k);
            r.pkt_last  = (k == BLOCKS - 1);
            r.strm_last = terminator;
            routed_words.push_back(r);
        end
    endtask

    task automatic route_word(input t_cmd_word it);
        int i;
        logic [7:0] hdr;
        hdr = {it.top, it.command, it.par};
        word_mem[it.pos] = it.word;
        if (it.pos != LAST_POS) return;
        if (it.s_end) begin
            for (i = 0; i < BLOCKS; i++) emit_words[i] = '0;
            route_hdr = '0;
            dup_run = '0;
            queue_packet(1'b1);
            return;
        end
        case (it.command)
            OP_SET_TABLE: begin
                for (i = 0; i < BLOCKS; i++) begin
                    lane_map[i] = word_mem[i][LANE_W-1:0];
                    emit_words[i] = '0;
                end
                route_dest = ALL_BLOCKS;
                route_hdr = {route_hdr[7], OP_RESET, route_hdr[2:0]};
                queue_packet(1'b0);
            end
            OP_DUP: begin
                for (i = 0; i < BLOCKS; i++) emit_words[i] = word_mem[i];
                route_dest = dup_dest(it.par, dup_run);
                route_hdr = hdr;
                queue_packet(1'b0);
                dup_run = dup_run + 1'b1;
            end
            OP_SEARCH: begin
                for (i = 0; i < BLOCKS; i++) emit_words[i] = word_mem[lane_map[i]];
                route_dest = ALL_BLOCKS;
                route_hdr = hdr;
                queue_packet(1'b0);
            end
            OP_RESET: begin
                for (i = 0; i < BLOCKS; i++) emit_words[i] = word_mem[i];
                route_dest = ALL_BLOCKS;
                route_hdr = hdr;
                queue_packet(1'b0);
            end
            default: begin
            end
        endcase
        if (it.command != OP_DUP) dup_run = '0;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_word(input t_cmd_word it);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= it.command;
        i_parallelism <= it.par;
        i_header_top  <= it.top;
        i_word        <= it.word;
        i_word_pos    <= it.pos;
        i_stream_end  <= it.s_end;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        route_word(it);
        in_count++;
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : check_out
        t_routed_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            out_count++;
            if (routed_words.size() == 0) begin
                $error("Output transfer with no word expected: pos %0h, word %0h",
                       o_out_pos, o_out_word);
                errors++;
            end else begin
                want = routed_words.pop_front();
                check_field("dest", WORD_W'(want.dest), WORD_W'(o_dest));
                check_field("out_header_top", WORD_W'(want.top),
                            WORD_W'(o_out_header_top));
                check_field("out_command", WORD_W'(want.command), WORD_W'(o_out_command));
                check_field("out_parallelism", WORD_W'(want.par),
                            WORD_W'(o_out_parallelism));
                check_field("out_word", want.word, o_out_word);
                check_field("out_pos", WORD_W'(want.pos), WORD_W'(o_out_pos));
                check_field("packet_last", WORD_W'(want.pkt_last), WORD_W'(o_packet_last));
                check_field("stream_last", WORD_W'(want.strm_last), WORD_W'(o_stream_last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timed out with %0d words still expected.", routed_words.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_terminator_from_reset();
        send_word(pack_word(OP_SEARCH, PAR_X4, 1'b1, $urandom, LAST_POS, 1'b1));
    endtask

    // Fills the whole buffer, so no later packet can read a word never written.
    task automatic test_reset_broadcast();
        int p;
        logic [WORD_W-1:0] w;
        for (p = 0; p < BLOCKS; p++) begin
            case (p)
                0: w = '0;
                1: w = '1;
                2: w = 32'hAAAA_AAAA;
                3: w = 32'h5555_5555;
                default: w = {28'($urandom_range(32'h0FFF_FFFF)), 4'((p * 5 + 2) % 16)};
            endcase
            if (p == BLOCKS - 1) begin
                send_word(pack_word(OP_RESET, 3'd7, 1'b1, w, LAST_POS, 1'b0));
            end else begin
                send_word(pack_word(CMD_W'($urandom_range(15)), PAR_W'($urandom_range(7)),
                                    1'b0, w, POS_W'(p), 1'b1));
            end
        end
    endtask

    task automatic test_set_table();
        send_word(pack_word(OP_SET_TABLE, PAR_X2, 1'b0, 32'h0000_000C, LAST_POS, 1'b0));
    endtask

    task automatic test_search();
        send_word(pack_word(OP_SEARCH, PAR_NONE, 1'b0, $urandom, LAST_POS, 1'b0));
    endtask

    task automatic test_dup_rows();
        logic [PAR_W-1:0] rows [6];
        int r;
        rows = '{PAR_X1, PAR_X2, PAR_X4, PAR_X8, PAR_X16, PAR_NONE};
        for (r = 0; r < 6; r++) begin
            send_word(pack_word(OP_DUP, rows[r], r[0], $urandom, LAST_POS, 1'b0));
        end
    endtask

    task automatic test_ignored_opcode();
        send_word(pack_word(OP_IGNORED, PAR_X1, 1'b1, $urandom, LAST_POS, 1'b0));
    endtask

    // Enough back-to-back duplicate updates to walk the count through a full wrap.
    task automatic test_dup_sweep(input int n_items);
        int n;
        logic [PAR_W-1:0] par;
        for (n = 0; n < n_items; n++) begin
            par = ($urandom_range(4) != 0) ? PAR_W'($urandom_range(5, 1))
                                           : PAR_W'($urandom_range(7));
            send_word(pack_word(OP_DUP, par, 1'($urandom_range(1)), $urandom, LAST_POS,
                                1'b0));
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int first;
        int p;
        int pick;
        logic [CMD_W-1:0] cmd;
        t_cmd_word it;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 75) begin
                first = ($urandom_range(3) == 0) ? 0 : $urandom_range(15);
                for (p = first; p < BLOCKS; p++) begin
                    it = pack_word(CMD_W'($urandom_range(15)), PAR_W'($urandom_range(7)),
                                   1'($urandom_range(1)), $urandom, POS_W'(p),
                                   1'($urandom_range(1)));
                    if (p == BLOCKS - 1) begin
                        pick = $urandom_range(9);
                        case (pick)
                            0, 1: cmd = OP_SEARCH;
                            2, 3: cmd = OP_SET_TABLE;
                            4, 5: cmd = OP_RESET;
                            6, 7: cmd = OP_DUP;
                            default: cmd = CMD_W'($urandom_range(15));
                        endcase
                        it.command = cmd;
                        it.s_end = ($urandom_range(9) == 0);
                    end
                    send_word(it);
                    sent++;
                end
            end else begin
                send_word(pack_word(CMD_W'($urandom_range(15)), PAR_W'($urandom_range(7)),
                                    1'($urandom_range(1)), $urandom,
                                    POS_W'($urandom_range(15)), 1'($urandom_range(1))));
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_command     = '0;
        i_parallelism = '0;
        i_header_top  = 1'b0;
        i_word        = '0;
        i_word_pos    = '0;
        i_stream_end  = 1'b0;
        for (int i = 0; i < BLOCKS; i++) begin
            word_mem[i] = '0;
            lane_map[i] = '0;
        end
        dup_run    = '0;
        route_dest = '0;
        route_hdr  = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_terminator_from_reset();
        test_reset_broadcast();
        test_set_table();
        test_search();
        test_dup_rows();
        test_ignored_opcode();

        test_random_traffic(25);

        send_gap_pct = 73;
        test_dup_sweep(132);

        send_gap_pct = 0;
        stall_pct    = 73;
        test_random_traffic(50);

        send_gap_pct = 30;
        stall_pct    = 30;
        test_random_traffic(50);

        i_valid <= 1'b0;
        while (routed_words.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("Sent %0d word transfers and checked %0d routed words under four idling phases.",
                 in_count, out_count);
        $display("Every opcode, the terminator and a full wrap of the duplicate count were run.");
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
